@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the bracketing block.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define TPB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tpb assertion failed");

// Checks that a condition never holds outside reset.
`define TPB_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tpb forbidden condition seen");

`endif

@@ rtl/core/tpb_pkg.sv @@
// Package of the table product bracketing block: types, codes and constants.
// Used by every module of the block; depends on nothing.
package tpb_pkg;

  localparam int unsigned MaxLen    = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned CntW      = 5;
  localparam int unsigned NumLet    = 3;
  localparam int unsigned TabDepth  = 2 ** (2 * IdxW);
  localparam logic [17:0] ProdReset = 18'd164229;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [1:0]        letter_t;
  typedef logic [2:0]        mask_t;
  typedef logic [2*IdxW-1:0] addr_t;
  typedef logic [17:0]       tbl_t;

  typedef struct packed {
    letter_t rch;
    letter_t lch;
    idx_t    split;
  } wit_t;

  typedef wit_t [NumLet-1:0] wit_row_t;

  typedef enum logic [2:0] {
    TkLetter   = 3'd0,
    TkOpen     = 3'd1,
    TkProduct  = 3'd2,
    TkClose    = 3'd3,
    TkNoSol    = 3'd4,
    TkOverflow = 3'd5
  } tok_kind_e;

  typedef enum logic {
    CfgProductTable = 1'b0,
    CfgTargetLetter = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StSolveRd,
    StSolveEv,
    StSolveWr,
    StChkRd,
    StChk,
    StOverflow,
    StFetch,
    StOpen,
    StUnwind
  } ctrl_state_e;

  typedef struct packed {
    letter_t symbol;
    logic    last_symbol;
  } in_t;

  typedef struct packed {
    tok_kind_e token_kind;
    letter_t   token_letter;
    logic      final_token;
  } out_t;

  typedef struct packed {
    logic     we_reach;
    logic     we_wit;
    addr_t    waddr;
    mask_t    wmask;
    wit_row_t wrow;
    logic     re_reach;
    addr_t    raddr_a;
    addr_t    raddr_b;
    logic     re_wit;
    addr_t    raddr_w;
  } tab_req_t;

  typedef struct packed {
    logic clear;
    logic step;
    idx_t pos;
  } ev_ctl_t;

  typedef struct packed {
    idx_t    start;
    idx_t    stop;
    letter_t rch;
    logic    phase;
  } frame_t;

endpackage

@@ rtl/core/table_product_bracketing_top.sv @@
// Channel   | Direction | Handshake        | Payload
// input     | in        | valid / stall    | tpb_pkg::in_t (symbol, last_symbol)
// output    | out       | valid / stall    | tpb_pkg::out_t (token_kind, token_letter, final)
// config    | in        | valid / ready    | cfg_index_i, cfg_data_i
// Letters load one per cycle while idle. After the last of n <= MAX_LEN letters the span walk
// covers every span of length 2..n; each split is a registered read of the reachable table
// and an evaluation step, and each span ends with a write. Then the target letter is checked.
// The bracketing walk issues its 4n-3 tokens, waiting whenever the output stalls.
// Reset clears the control state; the span tables need no clearing pass.
// The input is stalled from the final letter until the answer's last token is issued.
// Top level: configuration registers and the three parts; uses tpb_pkg.
module table_product_bracketing_top #(
  parameter int unsigned MAX_LEN = tpb_pkg::MaxLen
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tpb_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tpb_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [17:0]    cfg_data_i
);

  tpb_pkg::tbl_t     prod_table_q;
  tpb_pkg::letter_t  target_q;
  tpb_pkg::tab_req_t req;
  tpb_pkg::mask_t    rd_a, rd_b, ev_mask;
  tpb_pkg::wit_row_t wit_rd, ev_row;
  tpb_pkg::ev_ctl_t  ev;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_table_q <= tpb_pkg::ProdReset;
      target_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tpb_pkg::CfgProductTable) begin
        prod_table_q <= cfg_data_i;
      end else begin
        target_q <= cfg_data_i[1:0];
      end
    end
  end

  tpb_tables u_tables (
    .clk_i  (clk_i),
    .req_i  (req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b),
    .wit_o  (wit_rd)
  );

  tpb_split_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_i         (ev),
    .prod_table_i (prod_table_q),
    .rd_a_i       (rd_a),
    .rd_b_i       (rd_b),
    .mask_o       (ev_mask),
    .row_o        (ev_row)
  );

  tpb_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .target_i    (target_q),
    .req_o       (req),
    .rd_a_i      (rd_a),
    .wit_i       (wit_rd),
    .ev_o        (ev),
    .ev_mask_i   (ev_mask),
    .ev_row_i    (ev_row)
  );

endmodule

@@ rtl/core/tpb_tables.sv @@
// Span tables: reachable letter masks and witness rows, one entry per span.
// Synchronous memories with one write port and registered reads; uses tpb_pkg.
module tpb_tables (
  input  logic               clk_i,
  input  tpb_pkg::tab_req_t  req_i,
  output tpb_pkg::mask_t     rd_a_o,
  output tpb_pkg::mask_t     rd_b_o,
  output tpb_pkg::wit_row_t  wit_o
);

  tpb_pkg::mask_t    reach_mem [tpb_pkg::TabDepth];
  tpb_pkg::wit_row_t wit_mem   [tpb_pkg::TabDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we_reach) begin
      reach_mem[req_i.waddr] <= req_i.wmask;
    end
    if (req_i.we_wit) begin
      wit_mem[req_i.waddr] <= req_i.wrow;
    end
    if (req_i.re_reach) begin
      rd_a_o <= reach_mem[req_i.raddr_a];
      rd_b_o <= reach_mem[req_i.raddr_b];
    end
    if (req_i.re_wit) begin
      wit_o <= wit_mem[req_i.raddr_w];
    end
  end

endmodule

@@ rtl/core/tpb_split_eval.sv @@
// Split evaluator: per letter, keeps the lowest-pair (left, right, split) witness.
// Fed with the two sub-span masks of one split per step; uses tpb_pkg.
module tpb_split_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpb_pkg::ev_ctl_t   ev_i,
  input  tpb_pkg::tbl_t      prod_table_i,
  input  tpb_pkg::mask_t     rd_a_i,
  input  tpb_pkg::mask_t     rd_b_i,
  output tpb_pkg::mask_t     mask_o,
  output tpb_pkg::wit_row_t  row_o
);

  tpb_pkg::mask_t    found_q;
  logic [3:0]        bk_q [tpb_pkg::NumLet];
  tpb_pkg::wit_row_t row_q;
  tpb_pkg::mask_t    hit;
  logic [3:0]        hk [tpb_pkg::NumLet];
  tpb_pkg::wit_t     hw [tpb_pkg::NumLet];

  // The lowest pair index wins, so scan pairs from the top down.
  always_comb begin
    for (int ch = 0; ch < tpb_pkg::NumLet; ch++) begin
      hit[ch] = 1'b0;
      hk[ch]  = '0;
      hw[ch]  = '0;
      for (int k = 8; k >= 0; k--) begin
        if (prod_table_i[2*k +: 2] == 2'(ch) && rd_a_i[k/3] && rd_b_i[k%3]) begin
          hit[ch]      = 1'b1;
          hk[ch]       = 4'(k);
          hw[ch].split = ev_i.pos;
          hw[ch].lch   = 2'(k/3);
          hw[ch].rch   = 2'(k%3);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else if (ev_i.clear) begin
      found_q <= '0;
    end else if (ev_i.step) begin
      found_q <= found_q | hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_i.step && !ev_i.clear) begin
      for (int ch = 0; ch < tpb_pkg::NumLet; ch++) begin
        if (hit[ch] && (!found_q[ch] || hk[ch] < bk_q[ch])) begin
          bk_q[ch]  <= hk[ch];
          row_q[ch] <= hw[ch];
        end
      end
    end
  end

  assign mask_o = found_q;
  assign row_o  = row_q;

endmodule

@@ rtl/core/tpb_ctrl.sv @@
// Sequencer of the block: string load, overflow report, span table walk, answer check and
// bracketing walk with its frame stack and output register; uses tpb_pkg.
`include "assert_macros.svh"
module tpb_ctrl #(
  parameter int unsigned MAX_LEN = tpb_pkg::MaxLen
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tpb_pkg::in_t       in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tpb_pkg::out_t      out_data_o,
  input  tpb_pkg::letter_t   target_i,
  output tpb_pkg::tab_req_t  req_o,
  input  tpb_pkg::mask_t     rd_a_i,
  input  tpb_pkg::wit_row_t  wit_i,
  output tpb_pkg::ev_ctl_t   ev_o,
  input  tpb_pkg::mask_t     ev_mask_i,
  input  tpb_pkg::wit_row_t  ev_row_i
);

  localparam int unsigned LW   = $clog2(MAX_LEN);
  localparam int unsigned CntW = tpb_pkg::CntW;

  tpb_pkg::ctrl_state_e st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d, n_q, n_d, len_q, len_d, sp_q, sp_d, cnt_new;
  tpb_pkg::idx_t   i_q, i_d, pos_q, pos_d, ci_q, ci_d, cj_q, cj_d, j;
  tpb_pkg::letter_t cch_q, cch_d;
  tpb_pkg::letter_t letters_q [MAX_LEN];
  tpb_pkg::frame_t  stack_q [MAX_LEN];
  tpb_pkg::frame_t  top, push_frame;
  tpb_pkg::wit_t    w;
  logic            let_we, push, set_phase, emit, slot_free, out_valid_q;
  tpb_pkg::out_t   tok, out_q;

  assign j         = tpb_pkg::idx_t'({1'b0, i_q} + len_q - CntW'(1));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign top       = stack_q[LW'(sp_q - CntW'(1))];
  assign w         = wit_i[cch_q];
  assign cnt_new   = (cnt_q <= CntW'(MAX_LEN)) ? cnt_q + CntW'(1) : cnt_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; n_d = n_q; len_d = len_q; i_d = i_q; pos_d = pos_q;
    ci_d = ci_q; cj_d = cj_q; cch_d = cch_q; sp_d = sp_q;
    let_we = 1'b0; push = 1'b0; set_phase = 1'b0; emit = 1'b0;
    push_frame = '0; tok = '0; req_o = '0; ev_o = '0;
    in_stall_o = (st_q != tpb_pkg::StIdle);
    unique case (st_q)
      tpb_pkg::StIdle: begin
        ev_o.clear = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CntW'(MAX_LEN)) begin
            let_we         = 1'b1;
            req_o.we_reach = 1'b1;
            req_o.waddr    = {tpb_pkg::idx_t'(cnt_q), tpb_pkg::idx_t'(cnt_q)};
            req_o.wmask    = 3'(3'b001 << in_data_i.symbol);
          end
          cnt_d = cnt_new;
          if (in_data_i.last_symbol) begin
            cnt_d = '0; n_d = cnt_new; len_d = CntW'(2); i_d = '0; pos_d = '0;
            if (cnt_new > CntW'(MAX_LEN)) begin
              st_d = tpb_pkg::StOverflow;
            end else if (cnt_new == CntW'(1)) begin
              st_d = tpb_pkg::StChkRd;
            end else begin
              st_d = tpb_pkg::StSolveRd;
            end
          end
        end
      end
      tpb_pkg::StSolveRd: begin
        req_o.re_reach = 1'b1;
        req_o.raddr_a  = {i_q, pos_q};
        req_o.raddr_b  = {pos_q + tpb_pkg::idx_t'(1), j};
        st_d = tpb_pkg::StSolveEv;
      end
      tpb_pkg::StSolveEv: begin
        ev_o.step = 1'b1;
        ev_o.pos  = pos_q;
        if (pos_q + tpb_pkg::idx_t'(1) == j) begin
          st_d = tpb_pkg::StSolveWr;
        end else begin
          pos_d = pos_q + tpb_pkg::idx_t'(1);
          st_d  = tpb_pkg::StSolveRd;
        end
      end
      tpb_pkg::StSolveWr: begin
        req_o.we_reach = 1'b1;
        req_o.we_wit   = 1'b1;
        req_o.waddr    = {i_q, j};
        req_o.wmask    = ev_mask_i;
        req_o.wrow     = ev_row_i;
        ev_o.clear     = 1'b1;
        if ({1'b0, i_q} + len_q == n_q) begin
          if (len_q == n_q) begin
            st_d = tpb_pkg::StChkRd;
          end else begin
            len_d = len_q + CntW'(1); i_d = '0; pos_d = '0;
            st_d  = tpb_pkg::StSolveRd;
          end
        end else begin
          i_d   = i_q + tpb_pkg::idx_t'(1);
          pos_d = i_q + tpb_pkg::idx_t'(1);
          st_d  = tpb_pkg::StSolveRd;
        end
      end
      tpb_pkg::StChkRd: begin
        req_o.re_reach = 1'b1;
        req_o.raddr_a  = {tpb_pkg::idx_t'(0), tpb_pkg::idx_t'(n_q - CntW'(1))};
        st_d = tpb_pkg::StChk;
      end
      tpb_pkg::StChk: begin
        if (|(rd_a_i & 3'(3'b001 << target_i))) begin
          ci_d = '0; cj_d = tpb_pkg::idx_t'(n_q - CntW'(1)); cch_d = target_i; sp_d = '0;
          st_d = tpb_pkg::StFetch;
        end else if (slot_free) begin
          emit = 1'b1;
          tok.token_kind  = tpb_pkg::TkNoSol;
          tok.final_token = 1'b1;
          st_d = tpb_pkg::StIdle;
        end
      end
      tpb_pkg::StOverflow: begin
        if (slot_free) begin
          emit = 1'b1;
          tok.token_kind  = tpb_pkg::TkOverflow;
          tok.final_token = 1'b1;
          st_d = tpb_pkg::StIdle;
        end
      end
      tpb_pkg::StFetch: begin
        if (ci_q == cj_q) begin
          if (slot_free) begin
            emit = 1'b1;
            tok.token_kind   = tpb_pkg::TkLetter;
            tok.token_letter = letters_q[ci_q[LW-1:0]];
            tok.final_token  = (sp_q == '0);
            st_d = (sp_q == '0) ? tpb_pkg::StIdle : tpb_pkg::StUnwind;
          end
        end else begin
          req_o.re_wit  = 1'b1;
          req_o.raddr_w = {ci_q, cj_q};
          st_d = tpb_pkg::StOpen;
        end
      end
      tpb_pkg::StOpen: begin
        if (slot_free) begin
          emit = 1'b1;
          tok.token_kind   = tpb_pkg::TkOpen;
          push             = 1'b1;
          push_frame.start = w.split + tpb_pkg::idx_t'(1);
          push_frame.stop  = cj_q;
          push_frame.rch   = w.rch;
          push_frame.phase = 1'b0;
          sp_d  = sp_q + CntW'(1);
          cj_d  = w.split;
          cch_d = w.lch;
          st_d  = tpb_pkg::StFetch;
        end
      end
      tpb_pkg::StUnwind: begin
        if (slot_free) begin
          emit = 1'b1;
          if (!top.phase) begin
            tok.token_kind = tpb_pkg::TkProduct;
            set_phase = 1'b1;
            ci_d = top.start; cj_d = top.stop; cch_d = top.rch;
            st_d = tpb_pkg::StFetch;
          end else begin
            tok.token_kind  = tpb_pkg::TkClose;
            tok.final_token = (sp_q == CntW'(1));
            sp_d = sp_q - CntW'(1);
            if (sp_q == CntW'(1)) begin
              st_d = tpb_pkg::StIdle;
            end
          end
        end
      end
      default: begin
        st_d = tpb_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= tpb_pkg::StIdle;
      cnt_q       <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      sp_q        <= sp_d;
      out_valid_q <= emit | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    len_q <= len_d;
    i_q   <= i_d;
    pos_q <= pos_d;
    ci_q  <= ci_d;
    cj_q  <= cj_d;
    cch_q <= cch_d;
    if (emit) begin
      out_q <= tok;
    end
    if (let_we) begin
      letters_q[cnt_q[LW-1:0]] <= in_data_i.symbol;
    end
    if (push) begin
      stack_q[sp_q[LW-1:0]] <= push_frame;
    end
    if (set_phase) begin
      stack_q[LW'(sp_q - CntW'(1))].phase <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TPB_ASSERT(a_sp_bound, sp_q < CntW'(MAX_LEN))
  `TPB_ASSERT(a_idle_empty, (st_q == tpb_pkg::StIdle) |-> (sp_q == '0))
  `TPB_ASSERT(a_final_idle, (emit && tok.final_token) |=> (st_q == tpb_pkg::StIdle))
  `TPB_ASSERT_NEVER(a_split_range, (st_q == tpb_pkg::StSolveEv) && !(pos_q < j))

endmodule
